FILE: rtl/hgst_pkg.sv
// ----------------------------------------------------------------------------
// hgst_pkg
// Shared types, constants and the LED colour table of the hop gradient seed
// tracker.
// ----------------------------------------------------------------------------
package hgst_pkg;

	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOP_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TOTAL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF  = 2'd3;

	localparam logic [15:0] RESET_NODE_ID     = 16'd0;
	localparam logic [15:0] RESET_HOP_LIMIT   = 16'd250;
	localparam logic [15:0] RESET_BLINK_TOTAL = 16'd6;
	localparam logic [15:0] RESET_BLINK_HALF  = 16'd1;
	localparam logic [15:0] RESET_HOP_DIST    = 16'd250;

	localparam logic [7:0] MSG_BYTES = 8'd8;

	localparam logic [4:0] LVL_FULL = 5'd25;
	localparam logic [4:0] LVL_PART = 5'd10;
	localparam logic [4:0] LVL_OFF  = 5'd0;

	typedef struct packed {
		logic [15:0] node_id;
		logic [15:0] hop_limit;
		logic [15:0] blink_total;
		logic [15:0] blink_half;
	} cfg_t;

	typedef struct packed {
		logic        action;
		logic [31:0] now_ms;
		logic        user_packet;
		logic [7:0]  payload_len;
		logic [15:0] peer_seed_id;
		logic [31:0] peer_seed_time;
		logic [15:0] peer_dist;
		logic        spark;
	} item_t;

	typedef struct packed {
		logic [14:0] colour;
		logic        known;
		logic [15:0] seed_id;
		logic [31:0] seed_time;
		logic [15:0] hop_cnt;
		logic        changed;
	} result_t;

	// packed red, green, blue
	function automatic logic [14:0] steady_colour(input logic have, input logic [15:0] hops);
		logic [2:0] k;
		logic [14:0] c;
		k = hops[2:0] - 3'd1;
		case (k)
			3'd0:    c = {LVL_FULL, LVL_OFF,  LVL_OFF};
			3'd1:    c = {LVL_FULL, LVL_PART, LVL_OFF};
			3'd2:    c = {LVL_FULL, LVL_FULL, LVL_OFF};
			3'd3:    c = {LVL_OFF,  LVL_FULL, LVL_OFF};
			3'd4:    c = {LVL_OFF,  LVL_FULL, LVL_FULL};
			3'd5:    c = {LVL_OFF,  LVL_OFF,  LVL_FULL};
			3'd6:    c = {LVL_PART, LVL_OFF,  LVL_FULL};
			default: c = {LVL_FULL, LVL_OFF,  LVL_FULL};
		endcase
		if (!have) begin
			c = 15'd0;
		end else if (hops == 16'd0) begin
			c = {LVL_FULL, LVL_FULL, LVL_FULL};
		end
		return c;
	endfunction

endpackage

FILE: rtl/hgst_cfg.sv
// ----------------------------------------------------------------------------
// hgst_cfg
// Configuration register file: node id, hop limit and blink timing.
// ----------------------------------------------------------------------------
module hgst_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [hgst_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [15:0]                    wr_data,
	output hgst_pkg::cfg_t                 cfg
);

	hgst_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_id     <= hgst_pkg::RESET_NODE_ID;
			cfg_q.hop_limit   <= hgst_pkg::RESET_HOP_LIMIT;
			cfg_q.blink_total <= hgst_pkg::RESET_BLINK_TOTAL;
			cfg_q.blink_half  <= hgst_pkg::RESET_BLINK_HALF;
		end else if (wr_en) begin
			unique case (wr_index)
				hgst_pkg::CFG_NODE_ID:     cfg_q.node_id     <= wr_data;
				hgst_pkg::CFG_HOP_LIMIT:   cfg_q.hop_limit   <= wr_data;
				hgst_pkg::CFG_BLINK_TOTAL: cfg_q.blink_total <= wr_data;
				hgst_pkg::CFG_BLINK_HALF:  cfg_q.blink_half  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/hgst_core.sv
// ----------------------------------------------------------------------------
// hgst_core
// Seed and distance tracking, blink timer and LED colour. Computes the next
// state and the result of one item and commits the state on update.
// ----------------------------------------------------------------------------
module hgst_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              update,
	input  hgst_pkg::item_t   item,
	input  hgst_pkg::cfg_t    cfg,
	output hgst_pkg::result_t result
);

	logic        have_q, n_have;
	logic [15:0] ident_q, n_ident;
	logic [31:0] stamp_q, n_stamp;
	logic [15:0] dist_q, n_dist;
	logic [31:0] end_q, n_end;
	logic [31:0] next_q, n_next;
	logic        lit_q, n_lit;
	logic [14:0] led_q, n_led;

	logic        chg;
	logic        msg_ok;
	logic        newer;
	logic [16:0] cand_w;
	logic [15:0] cand;
	logic [14:0] steady;
	logic [31:0] s_end, s_next;
	logic        s_lit;
	logic [14:0] s_led;

	always_comb begin
		n_have  = have_q;
		n_ident = ident_q;
		n_stamp = stamp_q;
		n_dist  = dist_q;
		chg     = 1'b0;

		msg_ok = item.user_packet && (item.payload_len >= hgst_pkg::MSG_BYTES)
			&& (item.peer_seed_time != 32'd0);
		cand_w = {1'b0, item.peer_dist} + 17'd1;
		cand   = (cand_w > {1'b0, cfg.hop_limit}) ? cfg.hop_limit : cand_w[15:0];
		newer  = (item.peer_seed_time != stamp_q) ? (item.peer_seed_time > stamp_q)
			: (item.peer_seed_id < ident_q);

		if (!item.action) begin
			if (msg_ok) begin
				if (!have_q || newer) begin
					n_have  = 1'b1;
					n_ident = item.peer_seed_id;
					n_stamp = item.peer_seed_time;
					n_dist  = cand;
					chg     = 1'b1;
				end else if ((item.peer_seed_time == stamp_q)
					&& (item.peer_seed_id == ident_q) && (cand < dist_q)) begin
					n_dist = cand;
					chg    = 1'b1;
				end
			end
		end else if (item.spark) begin
			n_have  = 1'b1;
			n_ident = cfg.node_id;
			n_stamp = item.now_ms;
			n_dist  = 16'd0;
			chg     = 1'b1;
		end

		steady = hgst_pkg::steady_colour(n_have, n_dist);

		// blink restart on any seed or distance change
		s_end  = chg ? (item.now_ms + {16'd0, cfg.blink_total}) : end_q;
		s_next = chg ? (item.now_ms + {16'd0, cfg.blink_half}) : next_q;
		s_lit  = chg ? 1'b1 : lit_q;
		s_led  = chg ? steady : led_q;

		n_end  = s_end;
		n_next = s_next;
		n_lit  = s_lit;
		n_led  = s_led;

		// tick advances the blink
		if (item.action) begin
			if (s_end == 32'd0) begin
				n_led = steady;
			end else if (item.now_ms >= s_end) begin
				n_end = 32'd0;
				n_led = steady;
			end else if (item.now_ms >= s_next) begin
				n_next = s_next + {16'd0, cfg.blink_half};
				n_lit  = !s_lit;
				n_led  = s_lit ? 15'd0 : steady;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			ident_q <= 16'd0;
			stamp_q <= 32'd0;
			dist_q  <= hgst_pkg::RESET_HOP_DIST;
			end_q   <= 32'd0;
			next_q  <= 32'd0;
			lit_q   <= 1'b0;
			led_q   <= 15'd0;
		end else if (update) begin
			have_q  <= n_have;
			ident_q <= n_ident;
			stamp_q <= n_stamp;
			dist_q  <= n_dist;
			end_q   <= n_end;
			next_q  <= n_next;
			lit_q   <= n_lit;
			led_q   <= n_led;
		end
	end

	assign result.colour    = n_led;
	assign result.known     = n_have;
	assign result.seed_id   = n_ident;
	assign result.seed_time = n_stamp;
	assign result.hop_cnt   = n_dist;
	assign result.changed   = chg;

endmodule

FILE: rtl/hop_gradient_seed_tracker.sv
// ----------------------------------------------------------------------------
// hop_gradient_seed_tracker
// Follows the newest seed heard from neighbors or sparked locally, keeps the
// hop distance to it and drives a blinking rainbow LED colour.
//
//   channel  direction  handshake        payload
//   in       sink       in_valid/stall   action .. spark
//   out      source     out_valid/stall  led_red .. changed
//   cfg      sink       cfg_valid/ready  cfg_index, cfg_data
//
// One item per cycle while the output is not stalled. An item is registered
// on transfer, evaluated against the tracker state and its result registered
// in the output register. The state update is the only loop and closes
// through the core state registers. Reset clears the tracker to no seed
// and loads the register defaults. A stalled output holds its result; the
// input stalls only when both the input and the output register are full.
// ----------------------------------------------------------------------------
module hop_gradient_seed_tracker (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           action,
	input  logic [31:0]                    now_ms,
	input  logic                           user_packet,
	input  logic [7:0]                     payload_len,
	input  logic [15:0]                    peer_seed_id,
	input  logic [31:0]                    peer_seed_time,
	input  logic [15:0]                    peer_dist,
	input  logic                           spark,

	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [4:0]                     led_red,
	output logic [4:0]                     led_green,
	output logic [4:0]                     led_blue,
	output logic                           known,
	output logic [15:0]                    cur_seed_id,
	output logic [31:0]                    cur_seed_time,
	output logic [15:0]                    cur_dist,
	output logic                           changed,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hgst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);

	hgst_pkg::cfg_t    cfg;
	hgst_pkg::item_t   item_s1;
	hgst_pkg::result_t res;
	hgst_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              adv;

	assign cfg_ready = 1'b1;

	hgst_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv) begin
				valid_s2 <= valid_s1;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.action         <= action;
			item_s1.now_ms         <= now_ms;
			item_s1.user_packet    <= user_packet;
			item_s1.payload_len    <= payload_len;
			item_s1.peer_seed_id   <= peer_seed_id;
			item_s1.peer_seed_time <= peer_seed_time;
			item_s1.peer_dist      <= peer_dist;
			item_s1.spark          <= spark;
		end
		if (adv && valid_s1) begin
			res_s2 <= res;
		end
	end

	hgst_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.update (adv && valid_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res)
	);

	assign out_valid     = valid_s2;
	assign led_red       = res_s2.colour[14:10];
	assign led_green     = res_s2.colour[9:5];
	assign led_blue      = res_s2.colour[4:0];
	assign known         = res_s2.known;
	assign cur_seed_id   = res_s2.seed_id;
	assign cur_seed_time = res_s2.seed_time;
	assign cur_dist      = res_s2.hop_cnt;
	assign changed       = res_s2.changed;

endmodule

FILE: rtl/hgst_checker.sv
// ----------------------------------------------------------------------------
// hgst_checker
// Port level checks of the hop gradient seed tracker, bound to the top level.
// ----------------------------------------------------------------------------
module hgst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [4:0]  led_red,
	input logic [4:0]  led_green,
	input logic [4:0]  led_blue,
	input logic        known,
	input logic [15:0] cur_dist,
	input logic        changed
);

	logic seen_known_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_known_q <= 1'b0;
		end else if (out_valid && !out_stall && known) begin
			seen_known_q <= 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(led_red) && $stable(led_green)
			&& $stable(led_blue) && $stable(cur_dist) && $stable(changed))
		else $error("stalled result changed");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_changed_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && changed |-> known)
		else $error("update without a seed");

	a_dark_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !known |-> (led_red == 5'd0) && (led_green == 5'd0) && (led_blue == 5'd0))
		else $error("LED lit with no seed");

	a_known_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_known_q |-> known)
		else $error("seed lost");

endmodule

bind hop_gradient_seed_tracker hgst_checker u_hgst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.led_red   (led_red),
	.led_green (led_green),
	.led_blue  (led_blue),
	.known     (known),
	.cur_dist  (cur_dist),
	.changed   (changed)
);
